>>> design/sirs_pkg.sv
// Shared types, constants and the symbol table lookup for the radix symbol converter.
// No dependencies; imported by the divider and the top level.
package sirs_pkg;

    // Field and register widths
    localparam int VALUE_W   = 32;
    localparam int DIGIT_W   = 6;
    localparam int SYMBOL_W  = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Symbol table: seven 64-bit registers, eight symbols each
    localparam int SYM_REGS       = 7;
    localparam int SYMS_PER_REG   = 8;
    localparam int MAX_SYMBOLS_DEF = 56;
    localparam int SYM_IDX_W      = 6;

    // Digit store
    localparam int DIGIT_SLOTS = 32;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);
    localparam int DCOUNT_W    = $clog2(DIGIT_SLOTS + 1);

    // Divider: quotient bits retired per cycle
    localparam int BITS_PER_CYCLE = 4;
    localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_BASE = 3'd1;

    // Character codes
    localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [SYMBOL_W-1:0] CHAR_DEL   = 8'd127;
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [SYM_REGS-1:0][CFG_W-1:0] t_sym_regs;

    // Divider result, valid for the cycle in which done is high
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_res;

    // Symbol k is byte (k mod 8) of table register k/8
    function automatic logic [SYMBOL_W-1:0] sym_byte(input t_sym_regs regs,
                                                     input logic [SYM_IDX_W-1:0] idx);
        logic [SYMBOL_W-1:0] b;
        b = '0;
        if (idx[SYM_IDX_W-1:3] < 3'(SYM_REGS)) begin
            b = regs[idx[SYM_IDX_W-1:3]][{idx[2:0], 3'b000} +: SYMBOL_W];
        end
        return b;
    endfunction

endpackage

>>> design/sirs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sirs_div.sv
// Iterative divider: 32-bit dividend by a 6-bit divisor, a few quotient bits per cycle.
// Depends on sirs_pkg.
module sirs_div import sirs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [DIGIT_W-1:0] i_divisor,
    output t_div_res           o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VALUE_W-1:0]   r_quot;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   r_div;
    logic [VALUE_W-1:0]   n_quot;
    logic [DIGIT_W-1:0]   n_rem;

    // Restoring steps: shift in the top dividend bit, subtract if it fits
    always_comb begin
        logic [DIGIT_W:0]   part;
        logic [VALUE_W-1:0] q;
        logic [DIGIT_W-1:0] rm;
        q  = r_quot;
        rm = r_rem;
        for (int k = 0; k < BITS_PER_CYCLE; k++) begin
            part = {rm, q[VALUE_W-1]};
            q    = {q[VALUE_W-2:0], 1'b0};
            if (part >= {1'b0, r_div}) begin
                part = part - {1'b0, r_div};
                q[0] = 1'b1;
            end
            rm = part[DIGIT_W-1:0];
        end
        n_quot = q;
        n_rem  = rm;
    end

    // Sequencer: load on start, finish after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

>>> design/signed_integer_to_radix_symbols_top.sv
// Radix symbol converter: top level with sequencer, config registers and output register.
// Depends on sirs_pkg, sirs_ram and sirs_div.
//
// Each accepted item (a 32-bit signed value) is written out as symbol bytes in
// the radix set by symbol_count, digit d shown as table symbol d, most
// significant first, with '-' ahead of negative values and last on the final
// byte. An invalid table yields no bytes. The block takes one item at a time
// and stalls its input until the item is finished. Each item is accepted, the
// table is checked symbol by symbol, and each digit is then made in the shared
// divider (4 quotient bits per cycle, with start and write-back). Each digit
// symbol then takes a digit store read and a table lookup, after a minus sign
// if one is due; output stalls hold these steps. The worst case is a negative
// value in radix 2.
module signed_integer_to_radix_symbols_top import sirs_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    // Output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SYMBOL_W-1:0]   o_symbol,
    output logic                  o_last,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DSTART,
        S_DWAIT,
        S_MINUS,
        S_READ,
        S_LOAD
    } t_state;

    t_state                r_state;
    logic [DIGIT_W-1:0]    r_count;
    t_sym_regs             r_syms;
    logic                  r_neg;
    logic [VALUE_W-1:0]    r_mag;
    logic [SYM_IDX_W-1:0]  r_idx;
    logic [DCOUNT_W-1:0]   r_digits;
    logic                  r_o_valid;
    logic [SYMBOL_W-1:0]   r_o_symbol;
    logic                  r_o_last;

    logic                  in_take;
    logic                  out_free;
    logic                  out_load;
    logic [VALUE_W-1:0]    raw;
    logic [SYMBOL_W-1:0]   chk_sym;
    logic                  chk_dup;
    logic                  chk_bad;
    logic                  count_bad;
    t_div_res              div_res;
    logic                  ram_we;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [DIGIT_W-1:0]    ram_rdata;

    // Handshake terms
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign out_load = ((r_state == S_MINUS) || (r_state == S_LOAD)) && out_free;
    assign raw      = $unsigned(i_value);

    // Repeat check: compare against every symbol already passed
    always_comb begin
        chk_dup = 1'b0;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            if ((SYM_IDX_W'(k) < r_idx) && (sym_byte(r_syms, SYM_IDX_W'(k)) == chk_sym)) begin
                chk_dup = 1'b1;
            end
        end
    end

    // Table checks: radix range, then one symbol per cycle
    assign count_bad = (r_count < DIGIT_W'(2)) || (r_count > DIGIT_W'(MAX_SYMBOLS));
    assign chk_sym   = sym_byte(r_syms, r_idx);
    assign chk_bad   = (chk_sym <= CHAR_SPACE) || (chk_sym >= CHAR_DEL) ||
                       (chk_sym == CHAR_PLUS) || (chk_sym == CHAR_MINUS) ||
                       chk_dup;

    // Digit store
    assign ram_we    = (r_state == S_DWAIT) && div_res.done;
    assign ram_re    = (r_state == S_READ);
    assign ram_raddr = SLOT_W'(r_digits - 1'b1);

    sirs_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_digits[SLOT_W-1:0]),
        .i_wdata (div_res.rem),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared divider
    sirs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_mag),
        .i_divisor  (r_count),
        .o_res      (div_res)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= DIGIT_W'(10);
            r_syms  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SYMBOL_COUNT) begin
                r_count <= i_cfg_data[DIGIT_W-1:0];
            end else begin
                r_syms[CFG_IDX_W'(i_cfg_idx - CFG_SYMBOLS_BASE)] <= i_cfg_data;
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_digits  <= '0;
        end else begin
            if (r_o_valid && !i_stall && !out_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_neg    <= raw[VALUE_W-1];
                        r_mag    <= raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
                        r_idx    <= '0;
                        r_digits <= '0;
                        if (!count_bad) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (chk_bad) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == SYM_IDX_W'(r_count - 1'b1)) begin
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_res.done) begin
                        r_mag    <= div_res.quot;
                        r_digits <= r_digits + 1'b1;
                        if ((div_res.quot == '0) ||
                            (r_digits == DCOUNT_W'(DIGIT_SLOTS - 1))) begin
                            r_state <= r_neg ? S_MINUS : S_READ;
                        end else begin
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_MINUS: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_symbol <= CHAR_MINUS;
                        r_o_last   <= 1'b0;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_digits <= r_digits - 1'b1;
                    r_state  <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_symbol <= sym_byte(r_syms, ram_rdata);
                        r_o_last   <= (r_digits == '0);
                        r_state    <= (r_digits == '0) ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_o_valid;
    assign o_symbol = r_o_symbol;
    assign o_last   = r_o_last;

`ifndef ASSERT_OFF
    // Divider finishes only while the sequencer waits for it
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DWAIT))
        else $error("divider result outside the wait state");

    // A minus sign is never the final byte
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_symbol == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign flagged as last");

    // Digit store is never read with no digits left
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_digits != '0))
        else $error("digit store read underflow");
`endif

endmodule
